// File: src/phlm_pkg.sv
// Shared types and constants of the pixel hit local-maximum clustering core.
package phlm_pkg;

    localparam int MAX_HITS    = 32;
    localparam int MAX_RESULTS = 32;

    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int ROW_W      = 7;
    localparam int COL_W      = 6;
    localparam int CHG_W      = 16;
    localparam int SUM_W      = 21;
    localparam int SEED_IDX_W = 5;
    localparam int MASK_OUT_W = 32;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 64;

    typedef struct packed {
        logic [CHG_W-1:0] charge;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } hit_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH
    } state_t;

endpackage

// File: src/phlm_cell.sv
// One cell of the hit ring: holds a hit, passes it on, tests it against the probe hit.
module phlm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  phlm_pkg::cell_ctrl_t ctrl,
    input  logic                wr_sel,
    input  phlm_pkg::hit_t      wr_hit,
    input  phlm_pkg::hit_t      nb_hit,
    input  logic                nb_valid,
    input  phlm_pkg::hit_t      probe,
    output phlm_pkg::hit_t      hit_q,
    output logic                valid_q,
    output logic                kill,
    output logic                member
);

    phlm_pkg::hit_t hit_reg;
    phlm_pkg::hit_t hit_next;
    logic           valid_reg;
    logic           valid_next;
    logic           row_near;
    logic           col_near;
    logic           same_pixel;

    always_comb begin
        hit_next   = hit_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.load && wr_sel) begin
            hit_next   = wr_hit;
            valid_next = 1'b1;
        end else if (ctrl.shift) begin
            hit_next   = nb_hit;
            valid_next = nb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        hit_reg <= hit_next;
    end

    always_comb begin
        row_near = ({1'b0, hit_reg.row} == {1'b0, probe.row})
                || ({1'b0, hit_reg.row} == {1'b0, probe.row} + (phlm_pkg::ROW_W + 1)'(1))
                || ({1'b0, probe.row} == {1'b0, hit_reg.row} + (phlm_pkg::ROW_W + 1)'(1));
        col_near = ({1'b0, hit_reg.column} == {1'b0, probe.column})
                || ({1'b0, hit_reg.column} == {1'b0, probe.column} + (phlm_pkg::COL_W + 1)'(1))
                || ({1'b0, probe.column} == {1'b0, hit_reg.column} + (phlm_pkg::COL_W + 1)'(1));
        same_pixel = (hit_reg.row == probe.row) && (hit_reg.column == probe.column);
        member     = valid_reg && row_near && col_near;
        kill       = member && !same_pixel && (hit_reg.charge > probe.charge);
    end

    assign hit_q   = hit_reg;
    assign valid_q = valid_reg;

endmodule

// File: src/pixel_hit_local_max_clustering_core.sv
// Top level: hit ring, scan sequencer and result register of the clustering core.
//
// channel  dir  word                                                       marker
// s_       in   tdata: hit_row[6:0] hit_column[12:7] hit_charge[28:13]     tlast = last_hit
// m_       out  tdata: seed_index[4:0] member_mask[36:5] plane_charge[57:37]
//               tuser: overflow; tlast = last_cluster
//
// Hits load at one per cycle into the ring. The last hit starts the scan: the ring
// rotates once per cycle, cell 0 is broadcast to all cells, and after the last stored
// hit a closing flush state runs before the next hit is taken.
// The scan holds while the result register is full and not taken.
// aresetn is synchronous; it empties the ring and the result register.
module pixel_hit_local_max_clustering_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [phlm_pkg::S_DATA_W-1:0] s_tdata,   // hit_row, hit_column, hit_charge
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [phlm_pkg::M_DATA_W-1:0] m_tdata,   // seed_index, member_mask, plane_charge
    output logic                          m_tuser,   // overflow
    output logic                          m_tlast
);

    localparam int N = phlm_pkg::MAX_HITS;

    phlm_pkg::state_t state_reg, state_next;
    logic [phlm_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [phlm_pkg::SUM_W-1:0]     total_reg, total_next;
    logic                           ovf_reg, ovf_next;
    logic [phlm_pkg::IDX_W-1:0]     scan_reg, scan_next;
    logic [phlm_pkg::RES_CNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [phlm_pkg::SEED_IDX_W-1:0] pend_index_reg, pend_index_next;
    logic [phlm_pkg::MASK_OUT_W-1:0] pend_mask_reg, pend_mask_next;
    logic                           out_valid_reg, out_valid_next;
    logic [phlm_pkg::M_DATA_W-1:0]  out_data_reg, out_data_next;
    logic                           out_ovf_reg, out_ovf_next;
    logic                           out_last_reg, out_last_next;

    phlm_pkg::cell_ctrl_t ctrl;
    phlm_pkg::hit_t       in_hit;
    phlm_pkg::hit_t       hit_q [N];
    logic [N-1:0]         valid_vec;
    logic [N-1:0]         kill_vec;
    logic [N-1:0]         member_vec;
    logic [N-1:0]         wr_sel_vec;
    logic [2*N-1:0]       mask_dbl;
    logic [N-1:0]         mask_full;
    logic [phlm_pkg::SUM_W:0] sum_wide;
    logic                 in_accept;
    logic                 out_free;
    logic                 store_ok;
    logic                 is_seed;
    logic                 scan_end;

    assign in_hit.row    = s_tdata[phlm_pkg::ROW_W-1:0];
    assign in_hit.column = s_tdata[phlm_pkg::ROW_W +: phlm_pkg::COL_W];
    assign in_hit.charge = s_tdata[phlm_pkg::ROW_W + phlm_pkg::COL_W +: phlm_pkg::CHG_W];

    for (genvar k = 0; k < N; k++) begin : g_cell
        localparam int NB = (k + 1) % N;
        assign wr_sel_vec[k] = (count_reg == phlm_pkg::CNT_W'(k));
        phlm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .wr_sel   (wr_sel_vec[k]),
            .wr_hit   (in_hit),
            .nb_hit   (hit_q[NB]),
            .nb_valid (valid_vec[NB]),
            .probe    (hit_q[0]),
            .hit_q    (hit_q[k]),
            .valid_q  (valid_vec[k]),
            .kill     (kill_vec[k]),
            .member   (member_vec[k])
        );
    end

    // cell k holds hit (k + scan) mod N; rotate back to load order
    assign mask_dbl  = {member_vec, member_vec} << scan_reg;
    assign mask_full = mask_dbl[2*N-1:N];

    assign s_tready  = (state_reg == phlm_pkg::ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign store_ok  = count_reg < phlm_pkg::CNT_W'(N);
    assign is_seed   = !(|kill_vec);
    assign scan_end  = (phlm_pkg::CNT_W'(scan_reg) + phlm_pkg::CNT_W'(1)) == count_reg;
    assign sum_wide  = {1'b0, total_reg} + (phlm_pkg::SUM_W + 1)'(in_hit.charge);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        ovf_next        = ovf_reg;
        scan_next       = scan_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_index_next = pend_index_reg;
        pend_mask_next  = pend_mask_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        ctrl            = '0;

        case (state_reg)
            phlm_pkg::ST_LOAD: begin
                if (in_accept) begin
                    if (store_ok) begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + phlm_pkg::CNT_W'(1);
                        total_next = sum_wide[phlm_pkg::SUM_W] ? '1
                                   : sum_wide[phlm_pkg::SUM_W-1:0];
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        scan_next  = '0;
                        state_next = phlm_pkg::ST_SCAN;
                    end
                end
            end
            phlm_pkg::ST_SCAN: begin
                if (out_free) begin
                    ctrl.shift = 1'b1;
                    scan_next  = scan_reg + phlm_pkg::IDX_W'(1);
                    if (is_seed && (emit_cnt_reg < phlm_pkg::RES_CNT_W'(phlm_pkg::MAX_RESULTS)))
                    begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_data_next  = phlm_pkg::M_DATA_W'({total_reg, pend_mask_reg,
                                                                  pend_index_reg});
                            out_ovf_next   = ovf_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_index_next = phlm_pkg::SEED_IDX_W'(scan_reg);
                        pend_mask_next  = phlm_pkg::MASK_OUT_W'(mask_full);
                        emit_cnt_next   = emit_cnt_reg + phlm_pkg::RES_CNT_W'(1);
                    end
                    if (scan_end) begin
                        state_next = phlm_pkg::ST_FLUSH;
                    end
                end
            end
            phlm_pkg::ST_FLUSH: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_data_next  = phlm_pkg::M_DATA_W'({total_reg, pend_mask_reg,
                                                              pend_index_reg});
                        out_ovf_next   = ovf_reg;
                        out_last_next  = 1'b1;
                    end
                    ctrl.clear      = 1'b1;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    total_next      = '0;
                    ovf_next        = 1'b0;
                    emit_cnt_next   = '0;
                    state_next      = phlm_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = phlm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= phlm_pkg::ST_LOAD;
            count_reg      <= '0;
            total_reg      <= '0;
            ovf_reg        <= 1'b0;
            scan_reg       <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            ovf_reg        <= ovf_next;
            scan_reg       <= scan_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_index_reg <= pend_index_next;
        pend_mask_reg  <= pend_mask_next;
        out_data_reg   <= out_data_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule
